// ===== rtl/qsa_pkg.sv =====
// ----------------------------------------------------------------------------
// qsa_pkg: shared types and constants
// Types, encodings and helpers for the saturating Q32.32 arithmetic unit.
// ----------------------------------------------------------------------------
package qsa_pkg;

    localparam int FRAC_BITS = 32;
    localparam int NUM_CELLS = 128;

    localparam logic [63:0] NAN_RAW  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] PINF_RAW = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NINF_RAW = 64'h8000_0000_0000_0001;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;
    localparam logic [2:0] OP_NEG = 3'd6;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;
    localparam logic [1:0] ORD_UN = 2'd3;

    typedef enum logic [1:0] {
        SEL_PRE = 2'd0,
        SEL_MUL = 2'd1,
        SEL_DIV = 2'd2,
        SEL_MOD = 2'd3
    } sel_t;

    typedef struct packed {
        logic        valid;
        sel_t        sel;
        logic [63:0] value;
        logic [1:0]  order;
        logic        negative;
        logic        asign;
        logic [63:0] x;
        logic [63:0] d;
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } front_t;

    typedef struct packed {
        logic         valid;
        sel_t         sel;
        logic [63:0]  value;
        logic [1:0]   order;
        logic         negative;
        logic         asign;
        logic [63:0]  d;
        logic [63:0]  rem;
        logic [127:0] num;
        logic [63:0]  q;
        logic         ovf;
    } item_t;

    function automatic logic [63:0] neg64(input logic [63:0] v);
        return ~v + 64'd1;
    endfunction

    function automatic logic is_inf(input logic [63:0] v);
        return (v == PINF_RAW) || (v == NINF_RAW);
    endfunction

endpackage

// ===== rtl/qsa_front.sv =====
// ----------------------------------------------------------------------------
// qsa_front: operand decode and multiplier
// Two stages: special cases, add/sub/compare/negate and partial products,
// then product summation with saturation and chain set-up.
// ----------------------------------------------------------------------------
module qsa_front
    import qsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [2:0]   kind,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output item_t        dout
);

    front_t f_next;
    front_t f_reg;
    item_t  o_next;
    item_t  o_reg;

    logic [63:0]  s_add;
    logic [63:0]  s_sub;
    logic [64:0]  mid;
    logic [127:0] prod;
    logic         nan_in;
    logic         a_inf;
    logic         b_inf;

    always_comb
    begin
        f_next          = '0;
        f_next.valid    = in_valid;
        f_next.sel      = SEL_PRE;
        f_next.negative = a[63] ^ b[63];
        f_next.asign    = a[63];
        f_next.x        = a[63] ? neg64(a) : a;
        f_next.d        = b[63] ? neg64(b) : b;
        f_next.ll       = f_next.x[31:0]  * f_next.d[31:0];
        f_next.lh       = f_next.x[31:0]  * f_next.d[63:32];
        f_next.hl       = f_next.x[63:32] * f_next.d[31:0];
        f_next.hh       = f_next.x[63:32] * f_next.d[63:32];
        nan_in          = (a == NAN_RAW) || (b == NAN_RAW);
        a_inf           = is_inf(a);
        b_inf           = is_inf(b);
        s_add           = a + b;
        s_sub           = a - b;
        case (kind)
            OP_ADD:
            begin
                if (nan_in || (a == PINF_RAW && b == NINF_RAW) || (a == NINF_RAW && b == PINF_RAW))
                    f_next.value = NAN_RAW;
                else if (a_inf)
                    f_next.value = a;
                else if (b_inf)
                    f_next.value = b;
                else if (!(a[63] ^ b[63]) && (a[63] ^ s_add[63]))
                    f_next.value = (!s_add[63] && s_add != 64'd0) ? NINF_RAW : PINF_RAW;
                else if (s_add == NAN_RAW)
                    f_next.value = NINF_RAW;
                else
                    f_next.value = s_add;
            end
            OP_SUB:
            begin
                if (nan_in || (a_inf && b_inf && a == b))
                    f_next.value = NAN_RAW;
                else if (a_inf)
                    f_next.value = a;
                else if (b_inf)
                    f_next.value = neg64(b);
                else if ((a[63] ^ b[63]) && (a[63] ^ s_sub[63]))
                    f_next.value = (!s_sub[63] && s_sub != 64'd0) ? NINF_RAW : PINF_RAW;
                else if (s_sub == NAN_RAW)
                    f_next.value = NINF_RAW;
                else
                    f_next.value = s_sub;
            end
            OP_MUL:
            begin
                if (nan_in || (a == 64'd0 && b_inf) || (a_inf && b == 64'd0))
                    f_next.value = NAN_RAW;
                else if (a_inf || b_inf)
                    f_next.value = f_next.negative ? NINF_RAW : PINF_RAW;
                else
                    f_next.sel = SEL_MUL;
            end
            OP_DIV:
            begin
                if (nan_in || (a == 64'd0 && b == 64'd0) || (a_inf && b_inf))
                    f_next.value = NAN_RAW;
                else if (a_inf)
                    f_next.value = b[63] ? neg64(a) : a;
                else if (b_inf)
                    f_next.value = 64'd0;
                else if (b == 64'd0)
                    f_next.value = (!a[63] && a != 64'd0) ? PINF_RAW : NINF_RAW;
                else
                    f_next.sel = SEL_DIV;
            end
            OP_MOD:
            begin
                if (nan_in || a_inf || b == 64'd0)
                    f_next.value = NAN_RAW;
                else if (b_inf)
                    f_next.value = a;
                else
                    f_next.sel = SEL_MOD;
            end
            OP_CMP:
            begin
                if (nan_in)
                    f_next.order = ORD_UN;
                else if ($signed(a) > $signed(b))
                    f_next.order = ORD_GT;
                else if ($signed(a) < $signed(b))
                    f_next.order = ORD_LT;
                else
                    f_next.order = ORD_EQ;
            end
            OP_NEG:
                f_next.value = neg64(a);
            default:
                f_next.value = 64'd0;
        endcase
    end

    always_comb
    begin
        mid             = {1'b0, f_reg.lh} + {1'b0, f_reg.hl};
        prod            = {64'd0, f_reg.ll} + {31'd0, mid, 32'd0} + {f_reg.hh, 64'd0};
        o_next          = '0;
        o_next.valid    = f_reg.valid;
        o_next.sel      = (f_reg.sel == SEL_MUL) ? SEL_PRE : f_reg.sel;
        o_next.value    = f_reg.value;
        o_next.order    = f_reg.order;
        o_next.negative = f_reg.negative;
        o_next.asign    = f_reg.asign;
        o_next.d        = f_reg.d;
        o_next.num      = (f_reg.sel == SEL_DIV) ? ({64'd0, f_reg.x} << FRAC_BITS)
                                                 : {64'd0, f_reg.x};
        if (f_reg.sel == SEL_MUL)
        begin
            if ((|prod[127:64+FRAC_BITS]) || prod[63+FRAC_BITS])
                o_next.value = f_reg.negative ? NINF_RAW : PINF_RAW;
            else
                o_next.value = f_reg.negative ? neg64(prod[63+FRAC_BITS:FRAC_BITS])
                                              : prod[63+FRAC_BITS:FRAC_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg <= '0;
            o_reg <= '0;
        end
        else if (en)
        begin
            f_reg <= f_next;
            o_reg <= o_next;
        end
    end

    assign dout = o_reg;

endmodule

// ===== rtl/qsa_cell.sv =====
// ----------------------------------------------------------------------------
// qsa_cell: one restoring division step
// Shifts one dividend bit into the remainder and emits one quotient bit.
// ----------------------------------------------------------------------------
module qsa_cell
    import qsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  item_t din,
    output item_t dout
);

    item_t       cell_next;
    item_t       cell_reg;
    logic [64:0] trial;
    logic        qb;

    always_comb
    begin
        cell_next     = din;
        trial         = {din.rem, din.num[127]};
        qb            = (trial >= {1'b0, din.d});
        cell_next.rem = qb ? 64'(trial - {1'b0, din.d}) : trial[63:0];
        cell_next.num = {din.num[126:0], 1'b0};
        cell_next.q   = {din.q[62:0], qb};
        cell_next.ovf = din.ovf | din.q[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (en)
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

// ===== rtl/qsa_tail.sv =====
// ----------------------------------------------------------------------------
// qsa_tail: result select and output register
// Applies sign and saturation to quotient or remainder and holds the beat.
// ----------------------------------------------------------------------------
module qsa_tail
    import qsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  item_t       din,
    output logic        out_valid,
    output logic [63:0] out_value,
    output logic [1:0]  out_order
);

    logic        valid_reg;
    logic [63:0] value_reg;
    logic [1:0]  order_reg;
    logic [63:0] value_next;

    always_comb
    begin
        case (din.sel)
            SEL_DIV:
                if (din.ovf || din.q[63])
                    value_next = din.negative ? NINF_RAW : PINF_RAW;
                else
                    value_next = din.negative ? neg64(din.q) : din.q;
            SEL_MOD:
                value_next = din.asign ? neg64(din.rem) : din.rem;
            default:
                value_next = din.value;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            value_reg <= '0;
            order_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= din.valid;
            value_reg <= value_next;
            order_reg <= din.order;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_order = order_reg;

endmodule

// ===== rtl/q32_32_saturating_alu_top.sv =====
// Pipeline: an accepted input beat passes through 131 register stages
// (2 front stages, 128 division cells, 1 output register) to the output beat.
// Throughput: one beat per cycle; the whole chain stalls while an output
// beat waits and m_tready is low.
// Reset: rst_n asynchronous, active low, empties every stage.
// ----------------------------------------------------------------------------
// q32_32_saturating_alu_top: saturating Q32.32 arithmetic unit
// Add, subtract, multiply, divide, remainder, compare and negate.
// ----------------------------------------------------------------------------
module q32_32_saturating_alu_top
    import qsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // operand_a [63:0], operand_b [127:64]
    input  logic [2:0]   s_tuser,   // kind [2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // result_value [63:0], order [65:64], zero pad
);

    logic        en;
    logic [63:0] out_value;
    logic [1:0]  out_order;
    item_t       chain [NUM_CELLS+1];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    qsa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .kind     (s_tuser),
        .a        (s_tdata[63:0]),
        .b        (s_tdata[127:64]),
        .dout     (chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        qsa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    qsa_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .din       (chain[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_value (out_value),
        .out_order (out_order)
    );

    assign m_tdata = {6'd0, out_order, out_value};

endmodule
